// File: src/box_filter_image_downscaler_macros.svh
// Assertion macros for the box filter image downscaler checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef BOX_FILTER_IMAGE_DOWNSCALER_MACROS_SVH
`define BOX_FILTER_IMAGE_DOWNSCALER_MACROS_SVH
// Same-cycle implication, held off while reset is asserted.
`define BFID_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bfid: port check failed");
// Next-cycle implication, held off while reset is asserted.
`define BFID_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bfid: port check failed");
`endif

// File: src/bfid_pkg.sv
// Shared types and constants of the box filter image downscaler.
// No dependencies; imported by the top level.
`default_nettype none
package bfid_pkg;
	localparam int CFG_W  = 13;
	localparam int POS_W  = 13;
	localparam int DCOL_W = 11;
	localparam int PIX_W  = 8;
	localparam int NCH    = 4;
	localparam int SUM_W  = 40;
	localparam int PROD_W = 2 * POS_W;

	typedef enum logic [1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_DST_WIDTH  = 2'd2,
		REG_DST_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic [9:0] {
		S_EFF  = 10'b0000000001,
		S_BMUL = 10'b0000000010,
		S_BGO  = 10'b0000000100,
		S_BDIV = 10'b0000001000,
		S_IDLE = 10'b0000010000,
		S_ACC  = 10'b0000100000,
		S_AGO  = 10'b0001000000,
		S_ADIV = 10'b0010000000,
		S_OUT  = 10'b0100000000,
		S_UPD  = 10'b1000000000
	} state_t;

	typedef enum logic [1:0] {
		B_COL0 = 2'd0,
		B_ROW0 = 2'd1,
		B_COL  = 2'd2,
		B_ROW  = 2'd3
	} bnd_sel_t;

	typedef logic [NCH-1:0][SUM_W-1:0] sum_vec_t;
	typedef logic [NCH-1:0][PIX_W-1:0] pix_vec_t;
endpackage
`default_nettype wire

// File: src/bfid_sum_mem.sv
// Column sum memory: one write port and one registered read port.
// Self-contained; used by the top level.
`default_nettype none
module bfid_sum_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 160
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: src/bfid_div.sv
// Restoring divider, one quotient bit per cycle, quotient known to fit Q_W bits.
// Self-contained; used by the top level for block bounds and averages.
`default_nettype none
module bfid_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 26,
	parameter int Q_W   = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [Q_W-1:0]   quo
);
	localparam int SH_W  = DEN_W + Q_W - 1;
	localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [NUM_W-1:0] rem_q;
	logic [SH_W-1:0]  dsh_q;
	logic [Q_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CMP_W-1:0] rem_x, dsh_x, diff;
	logic             ge;

	assign rem_x = CMP_W'(rem_q);
	assign dsh_x = CMP_W'(dsh_q);
	assign ge    = rem_x >= dsh_x;
	assign diff  = rem_x - dsh_x;
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= SH_W'(den) << (Q_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= NUM_W'(diff);
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end
endmodule
`default_nettype wire

// File: src/box_filter_image_downscaler.sv
// Box filter image downscaler, top level.
// A pixel is taken in S_IDLE, summed in S_ACC and the raster position moves on in S_UPD;
// a pixel that closes a block also waits for the four 8-step average dividers and for the
// output to take its result, and one that opens a new block column or row waits for the 13-step bound divider.
// After reset or any configuration write, input stalls while the first bounds are computed;
// reset clears control state only, the column sum memory is never cleared.
`default_nettype none
module box_filter_image_downscaler
	import bfid_pkg::*;
#(
	parameter int MAX_SRC_WIDTH  = 4096,
	parameter int MAX_SRC_HEIGHT = 4096,
	parameter int MAX_DST_WIDTH  = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write_en,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       in_blue,
	input  wire logic [7:0]       in_green,
	input  wire logic [7:0]       in_red,
	input  wire logic [7:0]       in_alpha,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [7:0]       avg_blue,
	output logic      [7:0]       avg_green,
	output logic      [7:0]       avg_red,
	output logic      [7:0]       avg_alpha,
	output logic      [9:0]       dest_x,
	output logic      [11:0]      dest_y,
	output logic                  frame_end
);
	localparam int IDX_W = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
	localparam int CFG_X = CFG_W + 1;
	localparam logic [CFG_W:0] SW_MAX = CFG_X'(MAX_SRC_WIDTH);
	localparam logic [CFG_W:0] SH_MAX = CFG_X'(MAX_SRC_HEIGHT);
	localparam logic [CFG_W:0] TW_MAX = CFG_X'(MAX_DST_WIDTH);

	// Control state.
	state_t              state_q;
	bnd_sel_t            bsel_q;
	logic [CFG_W-1:0]    src_width_q, src_height_q, dst_height_q;
	logic [10:0]         dst_width_q;
	logic [POS_W-1:0]    src_col_q, src_row_q, dst_row_q;
	logic [DCOL_W-1:0]   dst_col_q;
	logic [POS_W-1:0]    col_start_q, col_end_q, row_start_q, row_end_q;
	logic [POS_W-1:0]    col0_q, row0_q, bnd_k_q;
	logic                out_valid_q;

	// Datapath registers.
	logic [POS_W-1:0]    sw_q, sh_q, tw_q, th_q;
	pix_vec_t            pix_q;
	sum_vec_t            sum_s1;
	logic [PROD_W-1:0]   prod_s1, area_s1;
	pix_vec_t            avg_q;
	pix_vec_t            avg_out_q;
	logic [DCOL_W-1:0]   dest_x_q;
	logic [POS_W-1:0]    dest_y_q;
	logic                fe_s1, frame_end_q;

	// The effective frame sizes: zero acts as one, sources saturate at their maximum and a
	// target never exceeds its source.
	logic [CFG_W:0] sw_x, sh_x, tw_x, th_x, sw_c, sh_c, tw_c, th_c, tw_m, th_m;

	assign sw_x = CFG_X'(src_width_q);
	assign sh_x = CFG_X'(src_height_q);
	assign tw_x = CFG_X'(dst_width_q);
	assign th_x = CFG_X'(dst_height_q);
	assign sw_c = (sw_x == '0) ? CFG_X'(1) : ((sw_x > SW_MAX) ? SW_MAX : sw_x);
	assign sh_c = (sh_x == '0) ? CFG_X'(1) : ((sh_x > SH_MAX) ? SH_MAX : sh_x);
	assign tw_c = (tw_x == '0) ? CFG_X'(1) : ((tw_x > TW_MAX) ? TW_MAX : tw_x);
	assign th_c = (th_x == '0) ? CFG_X'(1) : th_x;
	assign tw_m = (tw_c > sw_c) ? sw_c : tw_c;
	assign th_m = (th_c > sh_c) ? sh_c : th_c;

	// Position arithmetic for the pixel in flight.
	logic [POS_W-1:0] nc, nr, blk_w, blk_h, bnd_s, bnd_t;
	logic             first_pix, emit;

	assign nc        = src_col_q + POS_W'(1);
	assign nr        = src_row_q + POS_W'(1);
	assign blk_w     = col_end_q - col_start_q;
	assign blk_h     = row_end_q - row_start_q;
	assign first_pix = (src_col_q == col_start_q) && (src_row_q == row_start_q);
	assign emit      = (nc == col_end_q) && (nr == row_end_q);
	assign bnd_s     = (bsel_q == B_COL0 || bsel_q == B_COL) ? sw_q : sh_q;
	assign bnd_t     = (bsel_q == B_COL0 || bsel_q == B_COL) ? tw_q : th_q;

	// Column sum memory, one word holds the four channel sums of a destination column.
	logic [IDX_W-1:0] col_idx;
	sum_vec_t         mem_rd, sum_new;
	logic             mem_we;

	assign col_idx = IDX_W'(dst_col_q);
	assign mem_we  = (state_q == S_ACC);

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			sum_new[i] = first_pix ? SUM_W'(pix_q[i]) : (mem_rd[i] + SUM_W'(pix_q[i]));
		end
	end

	bfid_sum_mem #(
		.DEPTH (MAX_DST_WIDTH),
		.AW    (IDX_W),
		.DW    (NCH * SUM_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (col_idx),
		.wdata (sum_new),
		.raddr (col_idx),
		.rdata (mem_rd)
	);

	// Shared bound divider: floor(k * S / T) for every block edge.
	logic             bdiv_done;
	logic [POS_W-1:0] bnd_quo;

	bfid_div #(
		.NUM_W (PROD_W),
		.DEN_W (POS_W),
		.Q_W   (POS_W)
	) u_bnd_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_BGO),
		.num    (prod_s1),
		.den    (bnd_t),
		.done   (bdiv_done),
		.quo    (bnd_quo)
	);

	// One average divider per channel; all four run in lockstep.
	logic [NCH-1:0]    adiv_done;
	logic [PROD_W-1:0] area_den;

	assign area_den = (area_s1 == '0) ? PROD_W'(1) : area_s1;

	for (genvar g = 0; g < NCH; g++) begin : g_avg
		bfid_div #(
			.NUM_W (SUM_W),
			.DEN_W (PROD_W),
			.Q_W   (PIX_W)
		) u_avg_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (state_q == S_AGO),
			.num    (sum_s1[g]),
			.den    (area_den),
			.done   (adiv_done[g]),
			.quo    (avg_q[g])
		);
	end

	logic out_load;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// Sequencer. A configuration write always restarts the bound setup, and with it the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_EFF;
			bsel_q       <= B_COL0;
			src_width_q  <= 13'd1920;
			src_height_q <= 13'd1080;
			dst_width_q  <= 11'd480;
			dst_height_q <= 13'd270;
			src_col_q    <= '0;
			src_row_q    <= '0;
			dst_col_q    <= '0;
			dst_row_q    <= '0;
			col_start_q  <= '0;
			col_end_q    <= '0;
			row_start_q  <= '0;
			row_end_q    <= '0;
			col0_q       <= '0;
			row0_q       <= '0;
			bnd_k_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write_en) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_SRC_WIDTH:  src_width_q  <= cfg_data;
					REG_SRC_HEIGHT: src_height_q <= cfg_data;
					REG_DST_WIDTH:  dst_width_q  <= cfg_data[10:0];
					REG_DST_HEIGHT: dst_height_q <= cfg_data;
				endcase
				state_q <= S_EFF;
			end else begin
				unique case (state_q)
					S_EFF: begin
						src_col_q   <= '0;
						src_row_q   <= '0;
						dst_col_q   <= '0;
						dst_row_q   <= '0;
						col_start_q <= '0;
						row_start_q <= '0;
						bsel_q      <= B_COL0;
						bnd_k_q     <= POS_W'(1);
						state_q     <= S_BMUL;
					end
					S_BMUL: state_q <= S_BGO;
					S_BGO:  state_q <= S_BDIV;
					S_BDIV: begin
						if (bdiv_done) begin
							unique case (bsel_q)
								B_COL0: begin
									col0_q    <= bnd_quo;
									col_end_q <= bnd_quo;
									bsel_q    <= B_ROW0;
									state_q   <= S_BMUL;
								end
								B_ROW0: begin
									row0_q    <= bnd_quo;
									row_end_q <= bnd_quo;
									state_q   <= S_IDLE;
								end
								B_COL: begin
									col_end_q <= bnd_quo;
									state_q   <= S_IDLE;
								end
								B_ROW: begin
									row_end_q <= bnd_quo;
									state_q   <= S_IDLE;
								end
							endcase
						end
					end
					S_IDLE: begin
						if (in_valid) begin
							state_q <= S_ACC;
						end
					end
					S_ACC:  state_q <= emit ? S_AGO : S_UPD;
					S_AGO:  state_q <= S_ADIV;
					S_ADIV: begin
						if (&adiv_done) begin
							state_q <= S_OUT;
						end
					end
					S_OUT: begin
						if (out_load) begin
							state_q <= S_UPD;
						end
					end
					S_UPD: begin
						// Advance the raster position; a new block edge goes to the divider.
						priority if (nc >= sw_q) begin
							src_col_q   <= '0;
							dst_col_q   <= '0;
							col_start_q <= '0;
							col_end_q   <= col0_q;
							if (nr >= sh_q) begin
								src_row_q   <= '0;
								dst_row_q   <= '0;
								row_start_q <= '0;
								row_end_q   <= row0_q;
								state_q     <= S_IDLE;
							end else begin
								src_row_q <= nr;
								if (nr >= row_end_q) begin
									dst_row_q   <= dst_row_q + POS_W'(1);
									row_start_q <= row_end_q;
									bnd_k_q     <= dst_row_q + POS_W'(2);
									bsel_q      <= B_ROW;
									state_q     <= S_BMUL;
								end else begin
									state_q <= S_IDLE;
								end
							end
						end else if (nc >= col_end_q) begin
							src_col_q   <= nc;
							dst_col_q   <= dst_col_q + DCOL_W'(1);
							col_start_q <= col_end_q;
							bnd_k_q     <= POS_W'(dst_col_q) + POS_W'(2);
							bsel_q      <= B_COL;
							state_q     <= S_BMUL;
						end else begin
							src_col_q <= nc;
							state_q   <= S_IDLE;
						end
					end
					default: state_q <= S_EFF;
				endcase
			end
		end
	end

	// Datapath registers; none of them needs a reset. The result word is copied out of the
	// dividers when it is loaded, so a later block can start dividing while it waits.
	always_ff @(posedge clk) begin
		if (state_q == S_EFF) begin
			sw_q <= sw_c[POS_W-1:0];
			sh_q <= sh_c[POS_W-1:0];
			tw_q <= tw_m[POS_W-1:0];
			th_q <= th_m[POS_W-1:0];
		end
		if (state_q == S_BMUL) begin
			prod_s1 <= PROD_W'(bnd_k_q) * PROD_W'(bnd_s);
		end
		if (state_q == S_IDLE && in_valid) begin
			pix_q <= {in_alpha, in_red, in_green, in_blue};
		end
		if (state_q == S_ACC) begin
			sum_s1  <= sum_new;
			area_s1 <= PROD_W'(blk_w) * PROD_W'(blk_h);
			fe_s1   <= (nc == sw_q) && (nr == sh_q);
		end
		if (out_load) begin
			avg_out_q   <= avg_q;
			dest_x_q    <= dst_col_q;
			dest_y_q    <= dst_row_q;
			frame_end_q <= fe_s1;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign avg_blue  = avg_out_q[0];
	assign avg_green = avg_out_q[1];
	assign avg_red   = avg_out_q[2];
	assign avg_alpha = avg_out_q[3];
	assign dest_x    = dest_x_q[9:0];
	assign dest_y    = dest_y_q[11:0];
	assign frame_end = frame_end_q;
endmodule
`default_nettype wire

// File: src/bfid_port_check.sv
// Port-level checks of the box filter image downscaler, bound to the top level.
// Depends on box_filter_image_downscaler_macros.svh.
`default_nettype none
`include "box_filter_image_downscaler_macros.svh"
module bfid_port_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_write_en,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  avg_blue,
	input wire logic [7:0]  avg_green,
	input wire logic [7:0]  avg_red,
	input wire logic [7:0]  avg_alpha,
	input wire logic [9:0]  dest_x,
	input wire logic [11:0] dest_y,
	input wire logic        frame_end
);
	// A stalled result word stays and keeps its contents.
	`BFID_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`BFID_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(avg_blue) && $stable(avg_green) && $stable(avg_red) && $stable(avg_alpha) && $stable(dest_x) && $stable(dest_y) && $stable(frame_end))
	// A configuration write starts the bound setup, so no word is taken next cycle.
	`BFID_ASSERT_NEXT(a_cfg_stall, cfg_write_en, in_stall)
	// Pixels are handled one at a time.
	`BFID_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)
endmodule

bind box_filter_image_downscaler bfid_port_check u_port_check (.*);
`default_nettype wire
